[rtl/i2cmbe_pkg.sv]
// Package for the I2C master byte engine.
// Holds the command codes and the payload types of the tick and result channels.
package i2cmbe_pkg;

  localparam logic [2:0] MODE_CLEAR = 3'd0;
  localparam logic [2:0] MODE_START = 3'd1;
  localparam logic [2:0] MODE_STOP  = 3'd2;
  localparam logic [2:0] MODE_WRITE = 3'd3;
  localparam logic [2:0] MODE_READ  = 3'd4;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RETRY_LIMIT = 2'd1;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] mode;
    logic [7:0] write_byte;
    logic       send_ack;
    logic       sda_in;
  } tick_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       nack_seen;
  } result_t;

endpackage

[rtl/i2cmbe_stream_if.sv]
// Valid/ready channel interface for the I2C master byte engine.
// The payload type is set per instance, normally from i2cmbe_pkg.
interface i2cmbe_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/i2c_master_byte_engine_unit.sv]
// I2C master byte engine: one bus timer tick in, one result out per transfer.
// The result of a tick is registered in the output register when the tick transfers.
// Throughput: one tick per cycle unless rsp stalls; a new tick enters the same cycle the held result leaves.
// Reset (rst, synchronous, active high): engine idle, both lines released, half period 50,
// retry limit 255, held read byte and nack flag cleared, output register empty.
// Depends on i2cmbe_pkg and i2cmbe_stream_if.
module i2c_master_byte_engine_unit #(
  parameter int unsigned CLEAR_PULSES = 9
) (
  input  logic                                clk,
  input  logic                                rst,
  i2cmbe_stream_if.sink                       req,
  i2cmbe_stream_if.source                     rsp,
  input  logic                                cfg_we,
  input  logic [i2cmbe_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [i2cmbe_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import i2cmbe_pkg::*;

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_CLR_REL  = 4'd1;
  localparam logic [3:0] PH_CLR_LOW  = 4'd2;
  localparam logic [3:0] PH_CLR_HIGH = 4'd3;
  localparam logic [3:0] PH_ST_A     = 4'd4;
  localparam logic [3:0] PH_ST_B     = 4'd5;
  localparam logic [3:0] PH_ST_C     = 4'd6;
  localparam logic [3:0] PH_SP_A     = 4'd7;
  localparam logic [3:0] PH_SP_B     = 4'd8;
  localparam logic [3:0] PH_SP_C     = 4'd9;
  localparam logic [3:0] PH_BIT_LOW  = 4'd10;
  localparam logic [3:0] PH_BIT_HIGH = 4'd11;
  localparam logic [3:0] PH_ACK_LOW  = 4'd12;
  localparam logic [3:0] PH_ACK_HIGH = 4'd13;

  localparam logic [4:0] PULSES = 5'(CLEAR_PULSES);

  logic [15:0] half_period_ticks;
  logic [7:0]  ack_retry_limit;

  logic [3:0]  phase;
  logic [2:0]  active_mode;
  logic [3:0]  bit_index;
  logic [7:0]  shift_reg;
  logic [15:0] tick_count;
  logic [7:0]  retry_count;
  logic        ack_request;
  logic        scl_level;
  logic        sda_level;
  logic [7:0]  held_read;
  logic        held_nack;

  logic [3:0]  phase_next;
  logic [2:0]  active_mode_next;
  logic [3:0]  bit_index_next;
  logic [7:0]  shift_reg_next;
  logic [15:0] tick_count_next;
  logic [7:0]  retry_count_next;
  logic        ack_request_next;
  logic [1:0]  levels_next;
  logic [7:0]  held_read_next;
  logic        held_nack_next;

  logic [1:0]  levels_cmd;
  logic [15:0] half_period;
  logic        cmd_take;
  logic        busy;
  logic        done;
  logic        take;
  logic        out_valid;
  result_t     out_data;
  result_t     result_next;

  function automatic logic [1:0] step_levels(
    input logic [3:0] p,
    input logic [2:0] am,
    input logic [7:0] sh,
    input logic       ar,
    input logic [1:0] cur
  );
    logic [1:0] lv;
    lv = cur;
    case (p)
      PH_CLR_REL:  lv = 2'b11;
      PH_CLR_LOW:  lv = 2'b01;
      PH_CLR_HIGH: lv = 2'b11;
      PH_ST_A:     lv = 2'b11;
      PH_ST_B:     lv = 2'b10;
      PH_ST_C:     lv = 2'b00;
      PH_SP_A:     lv = 2'b00;
      PH_SP_B:     lv = 2'b10;
      PH_SP_C:     lv = 2'b11;
      PH_BIT_LOW:  lv = {1'b0, (am == MODE_WRITE) ? sh[7] : 1'b1};
      PH_BIT_HIGH: lv = {1'b1, cur[0]};
      PH_ACK_LOW:  lv = {1'b0, (am == MODE_WRITE) ? 1'b1 : ~ar};
      PH_ACK_HIGH: lv = {1'b1, cur[0]};
      default:     lv = cur;
    endcase
    return lv;
  endfunction

  assign take      = req.valid & req.ready;
  assign req.ready = ~out_valid | rsp.ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  assign half_period = (half_period_ticks == 16'd0) ? 16'd1 : half_period_ticks;

  always_comb begin
    phase_next       = phase;
    active_mode_next = active_mode;
    bit_index_next   = bit_index;
    shift_reg_next   = shift_reg;
    tick_count_next  = tick_count;
    retry_count_next = retry_count;
    ack_request_next = ack_request;
    levels_next      = {scl_level, sda_level};
    held_read_next   = held_read;
    held_nack_next   = held_nack;
    busy             = 1'b0;
    done             = 1'b0;

    // Take a command on an idle engine
    cmd_take = (phase == PH_IDLE) & req.data.cmd_valid & (req.data.mode <= MODE_READ);
    if (cmd_take) begin
      active_mode_next = req.data.mode;
      bit_index_next   = 4'd0;
      retry_count_next = 8'd0;
      tick_count_next  = 16'd0;
      case (req.data.mode)
        MODE_CLEAR: phase_next = PH_CLR_REL;
        MODE_START: phase_next = PH_ST_A;
        MODE_STOP:  phase_next = PH_SP_A;
        MODE_WRITE: begin
          shift_reg_next = req.data.write_byte;
          phase_next     = PH_BIT_LOW;
        end
        default: begin
          shift_reg_next   = 8'd0;
          ack_request_next = req.data.send_ack;
          phase_next       = PH_BIT_LOW;
        end
      endcase
      levels_next = step_levels(phase_next, active_mode_next, shift_reg_next,
                                ack_request_next, levels_next);
    end
    levels_cmd = levels_next;

    if (phase_next != PH_IDLE) begin
      busy = 1'b1;
      if (({1'b0, tick_count_next} + 17'd1) >= {1'b0, half_period}) begin
        tick_count_next = 16'd0;
        case (phase_next)
          PH_CLR_REL: begin
            bit_index_next = 4'd0;
            phase_next     = PH_CLR_LOW;
          end
          PH_CLR_LOW: phase_next = PH_CLR_HIGH;
          PH_CLR_HIGH: begin
            if (({1'b0, bit_index_next} + 5'd1) >= PULSES) begin
              phase_next = PH_IDLE;
              done       = 1'b1;
            end else begin
              bit_index_next = bit_index_next + 4'd1;
              phase_next     = PH_CLR_LOW;
            end
          end
          PH_ST_A: phase_next = PH_ST_B;
          PH_ST_B: phase_next = PH_ST_C;
          PH_ST_C: begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end
          PH_SP_A: phase_next = PH_SP_B;
          PH_SP_B: phase_next = PH_SP_C;
          PH_SP_C: begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end
          PH_BIT_LOW: phase_next = PH_BIT_HIGH;
          PH_BIT_HIGH: begin
            if (active_mode_next == MODE_WRITE) begin
              shift_reg_next = {shift_reg_next[6:0], 1'b0};
            end else begin
              shift_reg_next = {shift_reg_next[6:0], req.data.sda_in};
            end
            if (bit_index_next >= 4'd7) begin
              phase_next = PH_ACK_LOW;
            end else begin
              bit_index_next = bit_index_next + 4'd1;
              phase_next     = PH_BIT_LOW;
            end
          end
          PH_ACK_LOW: phase_next = PH_ACK_HIGH;
          PH_ACK_HIGH: begin
            phase_next = PH_IDLE;
            done       = 1'b1;
            if (active_mode_next == MODE_WRITE) begin
              if (!req.data.sda_in) begin
                held_nack_next = 1'b0;
              end else if (retry_count_next < ack_retry_limit) begin
                retry_count_next = retry_count_next + 8'd1;
                phase_next       = PH_ACK_LOW;
                done             = 1'b0;
              end else begin
                held_nack_next = 1'b1;
              end
            end else begin
              held_read_next = shift_reg_next;
            end
            if (done) begin
              levels_next = 2'b01;
            end
          end
          default: phase_next = PH_IDLE;
        endcase
        if (phase_next != PH_IDLE) begin
          levels_next = step_levels(phase_next, active_mode_next, shift_reg_next,
                                    ack_request_next, levels_next);
        end
      end else begin
        tick_count_next = tick_count_next + 16'd1;
      end
    end

    result_next.scl_out   = levels_cmd[1];
    result_next.sda_out   = levels_cmd[0];
    result_next.busy_res  = busy;
    result_next.done_res  = done;
    result_next.read_byte = held_read_next;
    result_next.nack_seen = held_nack_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= 16'd50;
      ack_retry_limit   <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HALF_PERIOD: half_period_ticks <= cfg_data;
        REG_RETRY_LIMIT: ack_retry_limit   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      active_mode <= MODE_CLEAR;
      bit_index   <= 4'd0;
      shift_reg   <= 8'd0;
      tick_count  <= 16'd0;
      retry_count <= 8'd0;
      ack_request <= 1'b0;
      scl_level   <= 1'b1;
      sda_level   <= 1'b1;
      held_read   <= 8'd0;
      held_nack   <= 1'b0;
    end else if (take) begin
      phase       <= phase_next;
      active_mode <= active_mode_next;
      bit_index   <= bit_index_next;
      shift_reg   <= shift_reg_next;
      tick_count  <= tick_count_next;
      retry_count <= retry_count_next;
      ack_request <= ack_request_next;
      scl_level   <= levels_next[1];
      sda_level   <= levels_next[0];
      held_read   <= held_read_next;
      held_nack   <= held_nack_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= result_next;
    end
  end

endmodule

[verif/i2c_master_byte_engine_unit_tb.sv]
// Testbench for i2c_master_byte_engine_unit: drives bus timer ticks, predicts every result
// with its own engine model and checks each result transfer in order.
// Depends on i2cmbe_pkg, i2cmbe_stream_if and the engine RTL.
`timescale 1ns / 1ps

import i2cmbe_pkg::*;

typedef enum logic [3:0] {
  ST_IDLE, ST_CLR_REL, ST_CLR_LOW, ST_CLR_HIGH,
  ST_START_A, ST_START_B, ST_START_C,
  ST_STOP_A, ST_STOP_B, ST_STOP_C,
  ST_BIT_LOW, ST_BIT_HIGH, ST_ACK_LOW, ST_ACK_HIGH
} bus_step_e;

class i2c_engine_scoreboard;
  int unsigned clear_pulses;
  logic [15:0] half_period;
  logic [7:0]  retry_limit;
  bus_step_e   step;
  logic [2:0]  cur_mode;
  logic [3:0]  bit_idx;
  logic [7:0]  shifter;
  logic [15:0] tick_cnt;
  logic [7:0]  retries;
  logic        ack_req;
  logic        scl;
  logic        sda;
  logic [7:0]  last_read;
  logic        last_nack;
  result_t     due_results[$];
  int unsigned errors;

  function new(int unsigned pulses);
    clear_pulses = pulses;
    half_period = 16'd50;
    retry_limit = 8'd255;
    step = ST_IDLE;
    cur_mode = '0;
    bit_idx = '0;
    shifter = '0;
    tick_cnt = '0;
    retries = '0;
    ack_req = 1'b0;
    scl = 1'b1;
    sda = 1'b1;
    last_read = '0;
    last_nack = 1'b0;
    errors = 0;
  endfunction

  function void configure(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    if (idx == REG_HALF_PERIOD) half_period = val;
    else if (idx == REG_RETRY_LIMIT) retry_limit = val[7:0];
  endfunction

  function bit engine_idle();
    return step == ST_IDLE;
  endfunction

  function bit in_write_ack();
    return cur_mode == MODE_WRITE && (step == ST_ACK_LOW || step == ST_ACK_HIGH);
  endfunction

  function int unsigned pending();
    return due_results.size();
  endfunction

  function void enter(bus_step_e s);
    step = s;
    tick_cnt = '0;
    case (s)
      ST_CLR_REL, ST_CLR_HIGH, ST_START_A, ST_STOP_C: begin
        scl = 1'b1;
        sda = 1'b1;
      end
      ST_CLR_LOW: begin
        scl = 1'b0;
        sda = 1'b1;
      end
      ST_START_B, ST_STOP_B: begin
        scl = 1'b1;
        sda = 1'b0;
      end
      ST_START_C, ST_STOP_A: begin
        scl = 1'b0;
        sda = 1'b0;
      end
      ST_BIT_LOW: begin
        scl = 1'b0;
        sda = (cur_mode == MODE_WRITE) ? shifter[7] : 1'b1;
      end
      ST_ACK_LOW: begin
        scl = 1'b0;
        sda = (cur_mode == MODE_WRITE) ? 1'b1 : !ack_req;
      end
      ST_BIT_HIGH, ST_ACK_HIGH: scl = 1'b1;
      default: ;
    endcase
  endfunction

  function void go_idle(bit byte_cmd);
    step = ST_IDLE;
    tick_cnt = '0;
    if (byte_cmd) begin
      scl = 1'b0;
      sda = 1'b1;
    end
  endfunction

  function bit end_step(logic sda_in);
    case (step)
      ST_CLR_REL: begin
        bit_idx = '0;
        enter(ST_CLR_LOW);
      end
      ST_CLR_LOW: enter(ST_CLR_HIGH);
      ST_CLR_HIGH: begin
        if (bit_idx + 1 >= clear_pulses) begin
          go_idle(1'b0);
          return 1'b1;
        end
        bit_idx = bit_idx + 1;
        enter(ST_CLR_LOW);
      end
      ST_START_A: enter(ST_START_B);
      ST_START_B: enter(ST_START_C);
      ST_STOP_A: enter(ST_STOP_B);
      ST_STOP_B: enter(ST_STOP_C);
      ST_START_C, ST_STOP_C: begin
        go_idle(1'b0);
        return 1'b1;
      end
      ST_BIT_LOW: enter(ST_BIT_HIGH);
      ST_BIT_HIGH: begin
        if (cur_mode == MODE_WRITE) shifter = {shifter[6:0], 1'b0};
        else shifter = {shifter[6:0], sda_in};
        if (bit_idx >= 4'd7) begin
          enter(ST_ACK_LOW);
        end else begin
          bit_idx = bit_idx + 1;
          enter(ST_BIT_LOW);
        end
      end
      ST_ACK_LOW: enter(ST_ACK_HIGH);
      ST_ACK_HIGH: begin
        if (cur_mode == MODE_WRITE) begin
          if (!sda_in) begin
            last_nack = 1'b0;
          end else if (retries < retry_limit) begin
            retries = retries + 1;
            enter(ST_ACK_LOW);
            return 1'b0;
          end else begin
            last_nack = 1'b1;
          end
        end else begin
          last_read = shifter;
        end
        go_idle(1'b1);
        return 1'b1;
      end
      default: go_idle(1'b0);
    endcase
    return 1'b0;
  endfunction

  function void note_tick(tick_t t);
    result_t r;
    logic [15:0] hp;
    r = '0;
    hp = (half_period == 16'd0) ? 16'd1 : half_period;
    if (step == ST_IDLE && t.cmd_valid && t.mode <= MODE_READ) begin
      cur_mode = t.mode;
      bit_idx = '0;
      retries = '0;
      case (t.mode)
        MODE_CLEAR: enter(ST_CLR_REL);
        MODE_START: enter(ST_START_A);
        MODE_STOP: enter(ST_STOP_A);
        MODE_WRITE: begin
          shifter = t.write_byte;
          enter(ST_BIT_LOW);
        end
        default: begin
          shifter = '0;
          ack_req = t.send_ack;
          enter(ST_BIT_LOW);
        end
      endcase
    end
    r.scl_out = scl;
    r.sda_out = sda;
    if (step != ST_IDLE) begin
      r.busy_res = 1'b1;
      if (tick_cnt + 1 >= hp) r.done_res = end_step(t.sda_in);
      else tick_cnt = tick_cnt + 1;
    end
    r.read_byte = last_read;
    r.nack_seen = last_nack;
    due_results.push_back(r);
  endfunction

  function void compare(string field, logic [7:0] exp, logic [7:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, actual %0h", field, exp, act);
      errors++;
    end
  endfunction

  function void check_result(result_t r);
    result_t e;
    if (due_results.size() == 0) begin
      $error("result transfer with no expected result");
      errors++;
      return;
    end
    e = due_results.pop_front();
    compare("scl_out", 8'(e.scl_out), 8'(r.scl_out));
    compare("sda_out", 8'(e.sda_out), 8'(r.sda_out));
    compare("busy_res", 8'(e.busy_res), 8'(r.busy_res));
    compare("done_res", 8'(e.done_res), 8'(r.done_res));
    compare("read_byte", e.read_byte, r.read_byte);
    compare("nack_seen", 8'(e.nack_seen), 8'(r.nack_seen));
  endfunction
endclass

module i2c_master_byte_engine_unit_tb;
  localparam int unsigned CLK_PERIOD = 10;
  localparam int unsigned CLEAR_PULSES = 9;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned RANDOM_TICKS = 100;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam logic [2:0] MODE_BAD_LO = 3'd5;
  localparam logic [2:0] MODE_BAD_MID = 3'd6;
  localparam logic [2:0] MODE_BAD_HI = 3'd7;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  i2cmbe_stream_if #(.T(tick_t)) req_ch ();
  i2cmbe_stream_if #(.T(result_t)) rsp_ch ();

  i2c_master_byte_engine_unit #(
    .CLEAR_PULSES(CLEAR_PULSES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  i2c_engine_scoreboard sb = new(CLEAR_PULSES);
  tick_t cmd_plan[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned nack_pct = 0;
  int unsigned sda_pct = 50;
  int unsigned quiet_cycles = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.data);
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void plan(bit valid, logic [2:0] mode, logic [7:0] data, bit ack);
    tick_t t;
    t = '0;
    t.cmd_valid = valid;
    t.mode = mode;
    t.write_byte = data;
    t.send_ack = ack;
    cmd_plan.push_back(t);
  endfunction

  function automatic tick_t make_tick(bit allow_random);
    tick_t t;
    int unsigned pick;
    t.cmd_valid = ($urandom_range(0, 3) == 0);
    t.mode = 3'($urandom_range(0, 7));
    t.write_byte = 8'($urandom_range(0, 255));
    t.send_ack = 1'($urandom_range(0, 1));
    if (sb.engine_idle()) begin
      if (cmd_plan.size() != 0) begin
        t = cmd_plan.pop_front();
      end else if (allow_random) begin
        pick = $urandom_range(0, 99);
        t.cmd_valid = ($urandom_range(0, 99) >= 8);
        if (pick < 38) t.mode = MODE_WRITE;
        else if (pick < 68) t.mode = MODE_READ;
        else if (pick < 80) t.mode = MODE_START;
        else if (pick < 92) t.mode = MODE_STOP;
        else if (pick < 96) t.mode = MODE_CLEAR;
        else t.mode = 3'($urandom_range(MODE_BAD_LO, MODE_BAD_HI));
      end
    end
    if (sb.in_write_ack()) t.sda_in = ($urandom_range(0, 99) < nack_pct);
    else t.sda_in = ($urandom_range(0, 99) < sda_pct);
    return t;
  endfunction

  // count = 0 runs the planned commands only; stops with the engine idle
  task automatic drive_ticks(input int unsigned count);
    int unsigned sent;
    logic taken;
    sent = 0;
    forever begin
      @(posedge clk);
      taken = req_ch.valid && req_ch.ready;
      if (taken) begin
        sb.note_tick(req_ch.data);
        sent++;
      end
      if (!req_ch.valid || taken) begin
        if (sent >= count && cmd_plan.size() == 0 && sb.engine_idle()) begin
          req_ch.valid <= 1'b0;
          break;
        end
        if ($urandom_range(0, 99) < send_idle_pct) begin
          req_ch.valid <= 1'b0;
        end else begin
          req_ch.data <= make_tick(sent < count);
          req_ch.valid <= 1'b1;
        end
      end
    end
  endtask

  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.configure(idx, val);
  endtask

  task automatic random_phase(input logic [15:0] hp, input logic [15:0] retry,
                              input int unsigned idle_pct, input int unsigned stall_pct);
    settle();
    write_reg(REG_HALF_PERIOD, hp);
    write_reg(REG_RETRY_LIMIT, retry);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    drive_ticks(RANDOM_TICKS);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset timing and limits
    plan(1'b1, MODE_START, 8'h00, 1'b0);
    drive_ticks(0);
    settle();

    write_reg(REG_HALF_PERIOD, 16'd1);
    write_reg(REG_RETRY_LIMIT, 16'hAB02);
    plan(1'b1, MODE_CLEAR, 8'h00, 1'b0);
    plan(1'b0, MODE_WRITE, 8'h00, 1'b0);
    plan(1'b1, MODE_START, 8'hFF, 1'b1);
    plan(1'b1, MODE_WRITE, 8'hFF, 1'b1);
    plan(1'b1, MODE_WRITE, 8'h00, 1'b0);
    plan(1'b1, MODE_BAD_LO, 8'h55, 1'b1);
    plan(1'b1, MODE_BAD_MID, 8'hAA, 1'b0);
    plan(1'b1, MODE_BAD_HI, 8'h0F, 1'b1);
    plan(1'b1, MODE_READ, 8'hF0, 1'b1);
    plan(1'b1, MODE_READ, 8'h00, 1'b0);
    plan(1'b1, MODE_STOP, 8'h00, 1'b0);
    drive_ticks(0);
    sda_pct = 100;
    plan(1'b1, MODE_READ, 8'h00, 1'b1);
    drive_ticks(0);
    sda_pct = 0;
    plan(1'b1, MODE_READ, 8'h00, 1'b0);
    drive_ticks(0);
    sda_pct = 50;

    // slave never acknowledges: retry, then give up; the last write is acknowledged
    nack_pct = 100;
    plan(1'b1, MODE_WRITE, 8'h5A, 1'b0);
    drive_ticks(0);
    settle();
    write_reg(REG_RETRY_LIMIT, 16'd0);
    write_reg(REG_SPARE_2, 16'd1);
    write_reg(REG_SPARE_3, 16'hFFFF);
    plan(1'b1, MODE_WRITE, 8'hC3, 1'b1);
    drive_ticks(0);
    settle();
    write_reg(REG_RETRY_LIMIT, 16'd12);
    plan(1'b1, MODE_WRITE, 8'h81, 1'b0);
    drive_ticks(0);
    nack_pct = 0;
    plan(1'b1, MODE_WRITE, 8'h7E, 1'b1);
    drive_ticks(0);

    settle();
    write_reg(REG_HALF_PERIOD, 16'd40);
    plan(1'b1, MODE_STOP, 8'h00, 1'b0);
    drive_ticks(0);

    nack_pct = 30;
    random_phase(16'd0, 16'd0, 0, 0);
    random_phase(16'd2, 16'd3, 59, 0);
    random_phase(16'd3, 16'd1, 0, 59);
    random_phase(16'd1, 16'd255, 33, 33);

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/i2cmbe_pkg.sv
rtl/i2cmbe_stream_if.sv
rtl/i2c_master_byte_engine_unit.sv
verif/i2c_master_byte_engine_unit_tb.sv
